[rtl/assert_macros.svh]
// Assertion macros shared by the translator RTL modules.
// Stand-alone header with no dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ptfm_pkg.sv]
// Shared types, constants and the attenuation table of the translator.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package ptfm_pkg;

   // Divider geometry: constant dividend over a 12-bit tone period.
   localparam int QUO_W     = 22;
   localparam int PERIOD_W  = 12;
   localparam int DIV_CNT_W = 5;

   localparam logic [QUO_W-1:0] DIVIDEND   = 22'd2345678;
   localparam logic [QUO_W-1:0] NORM_LIMIT = 22'd1024;

   // Tone generator register numbers.
   localparam logic [3:0] REG_TONE_FIRST = 4'd0;
   localparam logic [3:0] REG_TONE_LAST  = 4'd5;
   localparam logic [3:0] REG_MIXER      = 4'd7;
   localparam logic [3:0] REG_LEVEL_A    = 4'd8;
   localparam logic [3:0] REG_LEVEL_C    = 4'd10;

   // FM register addresses and fixed bytes.
   localparam logic [7:0] ADDR_FREQ_BASE   = 8'hA0;
   localparam logic [7:0] ADDR_BLOCK_BASE  = 8'hB0;
   localparam logic [7:0] ADDR_NOISE_FREQ  = 8'hA7;
   localparam logic [7:0] ADDR_NOISE_BLOCK = 8'hB7;
   localparam logic [7:0] ADDR_ATTEN_BASE  = 8'h43;
   localparam logic [7:0] ADDR_NOISE_ATTEN = 8'h54;
   localparam logic [7:0] BLOCK_FLAG       = 8'h20;

   localparam logic [2:0] NOISE_ALL_OFF = 3'b111;
   localparam logic [3:0] LEVEL_OFF     = 4'd0;
   localparam logic [3:0] LEVEL_FORCED  = 4'd12;
   localparam logic [1:0] CH_FINAL      = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_TONE,
      KIND_LEVEL
   } ptfm_kind_type;

   typedef enum logic [1:0] {
      RD_PERIOD_LO,
      RD_PERIOD_HI,
      RD_LEVEL
   } ptfm_rdsel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_LO,
      ST_RD_HI,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_NORM,
      ST_T_EMIT,
      ST_L_RD,
      ST_L_CAP,
      ST_L_EMIT
   } ptfm_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic           accept;
      logic           rd_en;
      ptfm_rdsel_type rd_sel;
      logic           cap_lo;
      logic           div_start;
      logic           q_load;
      logic           norm_en;
      logic           cap_lvl;
      logic           emit;
      logic           slot_inc;
      logic           ch_next;
   } ptfm_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      ptfm_kind_type kind;
      logic          div_done;
      logic          norm_done;
      logic          out_free;
      logic          slot_on;
      logic          slot_final;
      logic          seq_empty;
      logic          ch_last;
   } ptfm_status_type;

   // Level to FM attenuation byte.
   function automatic logic [7:0] atten_lookup(input logic [3:0] lvl);
      logic [7:0] res;
      unique case (lvl)
         4'd0:  res = 8'hFF;
         4'd1:  res = 8'h3F;
         4'd2:  res = 8'h3F;
         4'd3:  res = 8'h3F;
         4'd4:  res = 8'h2C;
         4'd5:  res = 8'h26;
         4'd6:  res = 8'h22;
         4'd7:  res = 8'h1D;
         4'd8:  res = 8'h16;
         4'd9:  res = 8'h12;
         4'd10: res = 8'h0C;
         4'd11: res = 8'h0A;
         4'd12: res = 8'h07;
         4'd13: res = 8'h05;
         4'd14: res = 8'h02;
         4'd15: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/ptfm_div.sv]
// Restoring divider: constant dividend over a 12-bit period, one bit per cycle.
// Depends on ptfm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptfm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ptfm_pkg::PERIOD_W-1:0] divisor,
   output logic                               done,
   output logic [ptfm_pkg::QUO_W-1:0]         quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [ptfm_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ptfm_pkg::PERIOD_W-1:0]      rem_ff, rem_in;
   logic [ptfm_pkg::PERIOD_W-1:0]      den_ff, den_in;
   logic [ptfm_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [ptfm_pkg::PERIOD_W:0]        partial;
   logic [ptfm_pkg::PERIOD_W:0]        diff;
   logic                               fits;

   always_comb begin
      partial = {rem_ff, ptfm_pkg::DIVIDEND[cnt_ff]};
      fits    = partial >= {1'b0, den_ff};
      diff    = partial - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         den_in = divisor;
         cnt_in = ptfm_pkg::DIV_CNT_W'(ptfm_pkg::QUO_W - 1);
         rem_in = '0;
         if (divisor == '0) begin
            // A zero period stands for a quotient of one.
            quo_in  = ptfm_pkg::QUO_W'(1);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            quo_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[ptfm_pkg::PERIOD_W-1:0] : partial[ptfm_pkg::PERIOD_W-1:0];
         quo_in = {quo_ff[ptfm_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `ASSERT_IMPLY(a_done_not_busy, clock, reset, done_ff, !busy_ff, "divider done while busy")
   `ASSERT_NEXT(a_last_step_done, clock, reset, busy_ff && (cnt_ff == '0) && !start, done_ff && !busy_ff, "divider missed its done pulse")

endmodule

`default_nettype wire

[rtl/ptfm_dp.sv]
// Datapath: shadow register file, divider, normalizer and the FM write builder.
// Depends on ptfm_pkg, ptfm_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptfm_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [3:0]              req_reg_index,
   input  wire logic [7:0]              req_reg_value,
   input  wire logic                    csr_valid,
   input  wire logic                    csr_ready,
   input  wire logic                    csr_noise_volume_enable,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_fm_address,
   output logic [7:0]                   rsp_fm_data,
   output logic                         rsp_last_write,
   input  wire ptfm_pkg::ptfm_cmd_type  cmd,
   output ptfm_pkg::ptfm_status_type    status
);

   // Shadow register file with per-entry valid bits; unwritten entries read zero.
   logic [7:0]  shadow_ff [16];
   logic [15:0] shadow_vld_ff, shadow_vld_in;
   logic [7:0]  rd_q_ff;
   logic        rd_vld_ff;
   logic [3:0]  rd_addr;
   logic [7:0]  rd_data;

   logic [5:0]              mix_ff, mix_in;
   logic                    nve_ff, nve_in;
   ptfm_pkg::ptfm_kind_type kind_ff, kind_in;
   logic [1:0]              ch_ff, ch_in;
   logic [1:0]              ch_last_ff, ch_last_in;
   logic [2:0]              slot_ff, slot_in;
   logic [7:0]              lo_ff, lo_in;
   logic [3:0]              lvl_ff, lvl_in;
   logic [ptfm_pkg::QUO_W-1:0] q_ff, q_in;
   logic [3:0]              shifts_ff, shifts_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_addr_ff, rsp_addr_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic                       div_done;
   logic [ptfm_pkg::QUO_W-1:0] div_quotient;

   logic       tone_on, noise_on, all_noise, lvl_noise_on;
   logic [7:0] mask, rest;
   logic [7:0] freq_byte, block_byte, atten_byte, silent_byte;
   logic [7:0] word_addr, word_data;
   logic       word_last, out_free;

   ptfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  ({rd_data[3:0], lo_ff}),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Read port address for the register the controller asks for.
   always_comb begin
      unique case (cmd.rd_sel)
         ptfm_pkg::RD_PERIOD_LO: rd_addr = {1'b0, ch_ff, 1'b0};
         ptfm_pkg::RD_PERIOD_HI: rd_addr = {1'b0, ch_ff, 1'b1};
         ptfm_pkg::RD_LEVEL:     rd_addr = ptfm_pkg::REG_LEVEL_A + {2'b00, ch_ff};
         default:                rd_addr = ptfm_pkg::REG_LEVEL_A;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         shadow_ff[req_reg_index] <= req_reg_value;
      end
      if (cmd.rd_en) begin
         rd_q_ff   <= shadow_ff[rd_addr];
         rd_vld_ff <= shadow_vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : 8'h00;

   // Slot masks: a tone sequence is two passes of tone then noise writes.
   always_comb begin
      tone_on      = !mix_ff[{1'b0, ch_ff}];
      noise_on     = !mix_ff[3'({1'b0, ch_ff}) + 3'd3];
      all_noise    = mix_ff[5:3] == ptfm_pkg::NOISE_ALL_OFF;
      lvl_noise_on = all_noise || nve_ff;
      if (kind_ff == ptfm_pkg::KIND_TONE) begin
         mask = {noise_on, noise_on, tone_on, tone_on, noise_on, noise_on, tone_on, tone_on};
      end else begin
         mask = {6'b000000, lvl_noise_on, 1'b1};
      end
      rest = mask >> slot_ff;
   end

   // The FM write that the current slot stands for.
   always_comb begin
      freq_byte   = q_ff[7:0];
      block_byte  = {2'b00, shifts_ff, q_ff[9:8]} | ptfm_pkg::BLOCK_FLAG;
      atten_byte  = ptfm_pkg::atten_lookup(lvl_ff);
      silent_byte = ptfm_pkg::atten_lookup(ptfm_pkg::LEVEL_OFF);
      if (kind_ff == ptfm_pkg::KIND_TONE) begin
         case (slot_ff[1:0])
            2'b00:   word_addr = ptfm_pkg::ADDR_FREQ_BASE + {6'b000000, ch_ff};
            2'b01:   word_addr = ptfm_pkg::ADDR_BLOCK_BASE + {6'b000000, ch_ff};
            2'b10:   word_addr = ptfm_pkg::ADDR_NOISE_FREQ;
            default: word_addr = ptfm_pkg::ADDR_NOISE_BLOCK;
         endcase
         word_data = slot_ff[0] ? block_byte : freq_byte;
      end else if (!slot_ff[0]) begin
         word_addr = ptfm_pkg::ADDR_ATTEN_BASE + {6'b000000, ch_ff};
         word_data = mix_ff[{1'b0, ch_ff}] ? silent_byte : atten_byte;
      end else begin
         word_addr = ptfm_pkg::ADDR_NOISE_ATTEN;
         word_data = all_noise ? silent_byte : atten_byte;
      end
      word_last = (rest == 8'd1) &&
                  ((kind_ff == ptfm_pkg::KIND_TONE) || (ch_ff == ch_last_ff));
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      shadow_vld_in = shadow_vld_ff;
      mix_in        = mix_ff;
      nve_in        = nve_ff;
      kind_in       = kind_ff;
      ch_in         = ch_ff;
      ch_last_in    = ch_last_ff;
      slot_in       = slot_ff;
      lo_in         = lo_ff;
      lvl_in        = lvl_ff;
      q_in          = q_ff;
      shifts_in     = shifts_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         nve_in = csr_noise_volume_enable;
      end

      if (cmd.accept) begin
         shadow_vld_in[req_reg_index] = 1'b1;
         slot_in = '0;
         if (req_reg_index == ptfm_pkg::REG_MIXER) begin
            mix_in = req_reg_value[5:0];
         end
         unique case (req_reg_index) inside
            [ptfm_pkg::REG_TONE_FIRST:ptfm_pkg::REG_TONE_LAST]: begin
               kind_in    = ptfm_pkg::KIND_TONE;
               ch_in      = req_reg_index[2:1];
               ch_last_in = req_reg_index[2:1];
            end
            ptfm_pkg::REG_MIXER: begin
               kind_in    = ptfm_pkg::KIND_LEVEL;
               ch_in      = 2'd0;
               ch_last_in = ptfm_pkg::CH_FINAL;
            end
            [ptfm_pkg::REG_LEVEL_A:ptfm_pkg::REG_LEVEL_C]: begin
               kind_in    = ptfm_pkg::KIND_LEVEL;
               ch_in      = req_reg_index[1:0];
               ch_last_in = req_reg_index[1:0];
            end
            default: begin
               kind_in = ptfm_pkg::KIND_NONE;
            end
         endcase
      end

      if (cmd.cap_lo) begin
         lo_in = rd_data;
      end
      if (cmd.cap_lvl) begin
         lvl_in  = rd_data[4] ? ptfm_pkg::LEVEL_FORCED : rd_data[3:0];
         slot_in = '0;
      end
      if (cmd.q_load) begin
         q_in      = div_quotient;
         shifts_in = '0;
      end else if (cmd.norm_en && (q_ff > ptfm_pkg::NORM_LIMIT)) begin
         q_in      = q_ff >> 1;
         shifts_in = shifts_ff + 1'b1;
      end
      if (cmd.slot_inc) begin
         slot_in = slot_ff + 1'b1;
      end
      if (cmd.ch_next) begin
         ch_in = ch_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = word_addr;
         rsp_data_in  = word_data;
         rsp_last_in  = word_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_vld_ff <= '0;
         mix_ff        <= '0;
         nve_ff        <= 1'b1;
         kind_ff       <= ptfm_pkg::KIND_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         shadow_vld_ff <= shadow_vld_in;
         mix_ff        <= mix_in;
         nve_ff        <= nve_in;
         kind_ff       <= kind_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      ch_last_ff  <= ch_last_in;
      slot_ff     <= slot_in;
      lo_ff       <= lo_in;
      lvl_ff      <= lvl_in;
      q_ff        <= q_in;
      shifts_ff   <= shifts_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status.kind       = kind_ff;
      status.div_done   = div_done;
      status.norm_done  = q_ff <= ptfm_pkg::NORM_LIMIT;
      status.out_free   = out_free;
      status.slot_on    = rest[0];
      status.slot_final = rest == 8'd1;
      status.seq_empty  = rest == 8'd0;
      status.ch_last    = ch_ff == ch_last_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fm_address = rsp_addr_ff;
   assign rsp_fm_data    = rsp_data_ff;
   assign rsp_last_write = rsp_last_ff;

   `ASSERT_IMPLY(a_tone_normalized, clock, reset, cmd.emit && (kind_ff == ptfm_pkg::KIND_TONE), q_ff <= ptfm_pkg::NORM_LIMIT, "tone word emitted before normalization finished")

endmodule

`default_nettype wire

[rtl/ptfm_ctrl.sv]
// Controller state machine that sequences reads, division and FM word output.
// Depends on ptfm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptfm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire ptfm_pkg::ptfm_status_type status,
   output ptfm_pkg::ptfm_cmd_type         cmd
);

   ptfm_pkg::ptfm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptfm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ptfm_pkg::ST_DECODE;
            end
         end
         ptfm_pkg::ST_DECODE: begin
            unique case (status.kind)
               ptfm_pkg::KIND_TONE:  state_in = ptfm_pkg::ST_RD_LO;
               ptfm_pkg::KIND_LEVEL: state_in = ptfm_pkg::ST_L_RD;
               default:              state_in = ptfm_pkg::ST_IDLE;
            endcase
         end
         ptfm_pkg::ST_RD_LO:  state_in = ptfm_pkg::ST_RD_HI;
         ptfm_pkg::ST_RD_HI:  state_in = ptfm_pkg::ST_DIV_GO;
         ptfm_pkg::ST_DIV_GO: state_in = ptfm_pkg::ST_DIV_WAIT;
         ptfm_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ptfm_pkg::ST_NORM;
            end
         end
         ptfm_pkg::ST_NORM: begin
            if (status.norm_done) begin
               state_in = ptfm_pkg::ST_T_EMIT;
            end
         end
         ptfm_pkg::ST_T_EMIT: begin
            if (status.seq_empty) begin
               state_in = ptfm_pkg::ST_IDLE;
            end else if (status.slot_on && status.out_free && status.slot_final) begin
               state_in = ptfm_pkg::ST_IDLE;
            end
         end
         ptfm_pkg::ST_L_RD:  state_in = ptfm_pkg::ST_L_CAP;
         ptfm_pkg::ST_L_CAP: state_in = ptfm_pkg::ST_L_EMIT;
         ptfm_pkg::ST_L_EMIT: begin
            if (status.slot_on && status.out_free && status.slot_final) begin
               state_in = status.ch_last ? ptfm_pkg::ST_IDLE : ptfm_pkg::ST_L_RD;
            end
         end
         default: state_in = ptfm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = ptfm_pkg::RD_PERIOD_LO;
      req_stall  = state_ff != ptfm_pkg::ST_IDLE;
      unique case (state_ff)
         ptfm_pkg::ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ptfm_pkg::ST_RD_LO: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ptfm_pkg::RD_PERIOD_LO;
         end
         ptfm_pkg::ST_RD_HI: begin
            cmd.cap_lo = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ptfm_pkg::RD_PERIOD_HI;
         end
         ptfm_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
         end
         ptfm_pkg::ST_DIV_WAIT: begin
            cmd.q_load = status.div_done;
         end
         ptfm_pkg::ST_NORM: begin
            cmd.norm_en = 1'b1;
         end
         ptfm_pkg::ST_T_EMIT: begin
            if (!status.seq_empty) begin
               if (!status.slot_on) begin
                  cmd.slot_inc = 1'b1;
               end else if (status.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.slot_inc = 1'b1;
               end
            end
         end
         ptfm_pkg::ST_L_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ptfm_pkg::RD_LEVEL;
         end
         ptfm_pkg::ST_L_CAP: begin
            cmd.cap_lvl = 1'b1;
         end
         ptfm_pkg::ST_L_EMIT: begin
            if (status.slot_on && status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.slot_inc = 1'b1;
               cmd.ch_next  = status.slot_final && !status.ch_last;
            end
         end
         default: begin
            cmd.accept = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptfm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPLY(a_emit_when_free, clock, reset, cmd.emit, status.out_free && status.slot_on, "word emitted into a busy output register")

endmodule

`default_nettype wire

[rtl/psg_to_fm_register_translator.sv]
// A tone period write holds the block through accept, decode, the two period reads, the
//    divider and the normalizer, then the slot steps, and longer while an FM write stalls.
// A level write holds it through accept, decode and, for each refreshed channel, a read,
//    a capture and its slots; other registers free it right after decode.
// Throughput: one word in flight; the next word is taken once the last FM write is registered.
// Reset (synchronous, active high) clears the shadow file to zero and sets noise_volume_enable.
`default_nettype none

// Top level of the tone generator to FM register translator.
// Depends on ptfm_pkg, ptfm_ctrl and ptfm_dp.
//
// Each accepted word is one write to a tone generator register. The datapath stores it in
// the shadow file, and the controller then walks a short list of output slots. For a tone
// period register the slots are two identical passes of (frequency, block) pairs for the
// tone voice and for the noise voice, each pair gated by its mixer bit. For the mixer and
// the level registers each refreshed channel has an attenuation slot and a noise
// attenuation slot. Disabled slots are skipped, and the final word that is actually
// written carries the last flag.
//
// The output register decouples the result channel, so a new word can be accepted while
// the final FM write still waits on a stalled consumer.
module psg_to_fm_register_translator (
   input  wire logic       clock,
   input  wire logic       reset,
   // Tone generator register writes.
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [3:0] req_reg_index,
   input  wire logic [7:0] req_reg_value,
   // FM register writes.
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_fm_address,
   output logic [7:0]      rsp_fm_data,
   output logic            rsp_last_write,
   // Configuration write port.
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_noise_volume_enable
);

   ptfm_pkg::ptfm_cmd_type    cmd;
   ptfm_pkg::ptfm_status_type status;

   // The configuration register is a single flop; writes always complete at once.
   assign csr_ready = 1'b1;

   ptfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptfm_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .req_reg_index           (req_reg_index),
      .req_reg_value           (req_reg_value),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_noise_volume_enable (csr_noise_volume_enable),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_fm_address          (rsp_fm_address),
      .rsp_fm_data             (rsp_fm_data),
      .rsp_last_write          (rsp_last_write),
      .cmd                     (cmd),
      .status                  (status)
   );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the tone generator to FM register translator.
// Depends only on the psg_to_fm_register_translator RTL; no package types are needed at the ports.
`default_nettype none

module tb_top;

   // Tone generator register numbers.
   localparam logic [3:0] REG_TONE_A_LO   = 4'd0;
   localparam logic [3:0] REG_TONE_A_HI   = 4'd1;
   localparam logic [3:0] REG_TONE_B_LO   = 4'd2;
   localparam logic [3:0] REG_TONE_B_HI   = 4'd3;
   localparam logic [3:0] REG_TONE_C_LO   = 4'd4;
   localparam logic [3:0] REG_TONE_C_HI   = 4'd5;
   localparam logic [3:0] REG_NOISE_PER   = 4'd6;
   localparam logic [3:0] REG_MIXER       = 4'd7;
   localparam logic [3:0] REG_LEVEL_A     = 4'd8;
   localparam logic [3:0] REG_LEVEL_B     = 4'd9;
   localparam logic [3:0] REG_LEVEL_C     = 4'd10;
   localparam logic [3:0] REG_ENV_FINE    = 4'd11;
   localparam logic [3:0] REG_ENV_COARSE  = 4'd12;
   localparam logic [3:0] REG_ENV_SHAPE   = 4'd13;
   localparam logic [3:0] REG_PORT_A      = 4'd14;
   localparam logic [3:0] REG_PORT_B      = 4'd15;

   // FM register addresses and fixed bytes.
   localparam logic [7:0] FM_FREQ_BASE    = 8'hA0;
   localparam logic [7:0] FM_BLOCK_BASE   = 8'hB0;
   localparam logic [7:0] FM_NOISE_FREQ   = 8'hA7;
   localparam logic [7:0] FM_NOISE_BLOCK  = 8'hB7;
   localparam logic [7:0] FM_ATTEN_BASE   = 8'h43;
   localparam logic [7:0] FM_NOISE_ATTEN  = 8'h54;
   localparam logic [7:0] FM_BLOCK_MARK   = 8'h20;

   localparam int unsigned TONE_DIVIDEND  = 2345678;
   localparam int unsigned FREQ_CEILING   = 1024;
   localparam logic [3:0]  LEVEL_FORCED   = 4'd12;
   localparam logic [3:0]  LEVEL_SILENT   = 4'd0;

   localparam logic [7:0] ATTEN_TABLE [16] = '{
      8'hFF, 8'h3F, 8'h3F, 8'h3F, 8'h2C, 8'h26, 8'h22, 8'h1D,
      8'h16, 8'h12, 8'h0C, 8'h0A, 8'h07, 8'h05, 8'h02, 8'h00
   };

   // Idle pauses last longer than a tone word that makes no FM write takes to finish.
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] data;
      logic       last;
   } fm_write_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_reg_index = '0;
   logic [7:0] req_reg_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_fm_address;
   logic [7:0] rsp_fm_data;
   logic       rsp_last_write;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_noise_volume_enable = 1'b0;

   // Our own copy of the block's state: the shadow file and the noise volume switch.
   logic [7:0] shadow_file [16];
   logic       noise_volume_on;

   // FM writes caused by the word being predicted, and all writes still owed by the block.
   fm_write_type  word_writes[$];
   fm_write_type  fm_writes_due[$];

   int             mismatch_count = 0;
   int             burst_left = 0;
   int             cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_mode_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   psg_to_fm_register_translator u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_reg_index           (req_reg_index),
      .req_reg_value           (req_reg_value),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_fm_address          (rsp_fm_address),
      .rsp_fm_data             (rsp_fm_data),
      .rsp_last_write          (rsp_last_write),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_noise_volume_enable (csr_noise_volume_enable)
   );

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   function automatic void owe_write(input logic [7:0] address, input logic [7:0] data);
      fm_write_type w;
      w.address = address;
      w.data    = data;
      w.last    = 1'b0;
      word_writes.push_back(w);
   endfunction

   // One pass over the tone voice and the noise voice of a channel, each gated by the
   // mixer, where a set bit means that voice is disabled.
   function automatic void owe_tone_pass(input int ch, input logic [7:0] freq,
                                         input logic [7:0] blk);
      logic [7:0] mix;
      mix = shadow_file[REG_MIXER];
      if (!mix[ch]) begin
         owe_write(FM_FREQ_BASE + 8'(ch), freq);
         owe_write(FM_BLOCK_BASE + 8'(ch), blk);
      end
      if (!mix[ch + 3]) begin
         owe_write(FM_NOISE_FREQ, freq);
         owe_write(FM_NOISE_BLOCK, blk);
      end
   endfunction

   // The 12-bit period divides the constant, and the quotient is halved until it is no
   // more than 1024. The shift count lands in the block byte from bit 2 up and may
   // spill into the upper bits; that is kept as the block writes it.
   function automatic void predict_tone(input int ch);
      logic [11:0] period;
      int unsigned quotient;
      int unsigned shifts;
      logic [7:0]  freq;
      logic [7:0]  blk;
      period   = {shadow_file[2 * ch + 1][3:0], shadow_file[2 * ch]};
      quotient = (period == 0) ? 1 : TONE_DIVIDEND / period;
      shifts   = 0;
      while (quotient > FREQ_CEILING) begin
         quotient = quotient >> 1;
         shifts++;
      end
      freq = quotient[7:0];
      blk  = 8'(quotient[9:8]) | 8'(shifts << 2) | FM_BLOCK_MARK;
      // The whole sequence goes out twice.
      owe_tone_pass(ch, freq, blk);
      owe_tone_pass(ch, freq, blk);
   endfunction

   // Attenuation refresh of one channel. Bit 4 of the level forces level 12, and the
   // level is then cut to four bits, so an oversized level never indexes past the table.
   function automatic void predict_level(input int ch);
      logic [7:0] raw;
      logic [7:0] mix;
      logic [3:0] lvl;
      raw = shadow_file[REG_LEVEL_A + 4'(ch)];
      mix = shadow_file[REG_MIXER];
      lvl = raw[4] ? LEVEL_FORCED : raw[3:0];
      owe_write(FM_ATTEN_BASE + 8'(ch), mix[ch] ? ATTEN_TABLE[LEVEL_SILENT] : ATTEN_TABLE[lvl]);
      if (mix[5:3] == 3'b111) begin
         owe_write(FM_NOISE_ATTEN, ATTEN_TABLE[LEVEL_SILENT]);
      end else if (noise_volume_on) begin
         owe_write(FM_NOISE_ATTEN, ATTEN_TABLE[lvl]);
      end
   endfunction

   // Store the word in the shadow file and append the FM writes it causes to the list of
   // writes owed, with the last flag on the final one.
   function automatic void predict_word(input logic [3:0] idx, input logic [7:0] val);
      fm_write_type w;
      word_writes.delete();
      shadow_file[idx] = val;
      if (idx <= REG_TONE_C_HI) begin
         predict_tone(int'(idx) / 2);
      end else if (idx == REG_MIXER) begin
         predict_level(0);
         predict_level(1);
         predict_level(2);
      end else if (idx >= REG_LEVEL_A && idx <= REG_LEVEL_C) begin
         predict_level(int'(idx - REG_LEVEL_A));
      end
      if (word_writes.size() > 0) begin
         w = word_writes.pop_back();
         w.last = 1'b1;
         word_writes.push_back(w);
      end
      foreach (word_writes[i]) fm_writes_due.push_back(word_writes[i]);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driving the block
   // ---------------------------------------------------------------------------------------

   // Sends one tone generator word. The sender works in bursts: when a burst runs out,
   // valid drops for a random gap and a new burst length is drawn. Now and then a burst
   // is long, which gives stretches of back-to-back words. Valid is never lowered between
   // two words of the same burst, and the payload holds while the block stalls.
   task automatic send_word(input logic [3:0] idx, input logic [7:0] val);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      end
      req_valid     <= 1'b1;
      req_reg_index <= idx;
      req_reg_value <= val;
      do @(posedge clock); while (req_stall);
      predict_word(idx, val);
      burst_left--;
   endtask

   // Brings the block to idle: no more words, every owed write seen, and then enough
   // cycles for a word that causes no FM write at all to be finished too.
   task automatic drain_block();
      req_valid <= 1'b0;
      burst_left = 0;
      while (fm_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the noise volume enable register; only called while the block is idle.
   task automatic write_noise_volume(input logic enable);
      csr_valid               <= 1'b1;
      csr_noise_volume_enable <= enable;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      noise_volume_on = enable;
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Tone periods with every voice enabled: a zero period (quotient of one), the shortest
   // period (most shifts), the longest, and high bytes whose upper nibble must be dropped.
   task automatic test_tone_periods();
      send_word(REG_TONE_A_LO, 8'h00);
      send_word(REG_TONE_A_LO, 8'h01);
      send_word(REG_TONE_A_HI, 8'hFF);
      send_word(REG_TONE_A_LO, 8'hFF);
      send_word(REG_TONE_B_LO, 8'h80);
      send_word(REG_TONE_B_HI, 8'hF0);
      send_word(REG_TONE_C_HI, 8'h0F);
      send_word(REG_TONE_C_LO, 8'h23);
   endtask

   // Levels and mixer: full level, the forcing bit, an oversized byte, all noise off,
   // tones off with noise on, a tone write with only its noise voice left, and a tone
   // write with both voices disabled, which causes no FM write at all.
   task automatic test_levels_and_mixer();
      send_word(REG_LEVEL_A, 8'h0F);
      send_word(REG_LEVEL_B, 8'h10);
      send_word(REG_LEVEL_C, 8'hFF);
      send_word(REG_MIXER, 8'h38);
      send_word(REG_MIXER, 8'h07);
      send_word(REG_TONE_B_LO, 8'h40);
      send_word(REG_MIXER, 8'h3F);
      send_word(REG_TONE_A_LO, 8'h12);
      send_word(REG_MIXER, 8'h00);
   endtask

   // Registers that are only stored.
   task automatic test_ignored_registers();
      send_word(REG_NOISE_PER, 8'hAA);
      send_word(REG_ENV_FINE, 8'hFF);
      send_word(REG_ENV_COARSE, 8'h00);
      send_word(REG_ENV_SHAPE, 8'h55);
      send_word(REG_PORT_A, 8'hFF);
      send_word(REG_PORT_B, 8'h00);
   endtask

   // With the noise volume switched off, level refreshes write no noise attenuation
   // unless all noise voices are off.
   task automatic test_noise_volume_off();
      write_noise_volume(1'b0);
      send_word(REG_LEVEL_A, 8'h05);
      send_word(REG_MIXER, 8'h08);
      send_word(REG_MIXER, 8'hF8);
   endtask

   // Random words, weighted toward the registers that cause FM writes. Mixer bytes often
   // turn all noise off, and tone high bytes are often zero so short periods show up.
   task automatic test_random_traffic(input int count);
      int         pick;
      logic [3:0] idx;
      logic [7:0] val;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         val  = 8'($urandom_range(0, 255));
         if (pick < 40) begin
            idx = REG_TONE_A_LO + 4'($urandom_range(0, 5));
            if (idx[0] && $urandom_range(0, 3) == 0) val = 8'h00;
         end else if (pick < 55) begin
            idx = REG_MIXER;
            if ($urandom_range(0, 2) == 0) val[5:3] = 3'b111;
         end else if (pick < 85) begin
            idx = REG_LEVEL_A + 4'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 0) val = 8'($urandom_range(0, 31));
         end else begin
            pick = $urandom_range(0, 5);
            idx  = (pick == 0) ? REG_NOISE_PER : REG_LEVEL_C + 4'(pick);
         end
         send_word(idx, val);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------------------

   // The consumer stalls on a pattern of its own: it switches between never stalling,
   // light and heavy random stalls, and a fixed periodic pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = stall_mode_type'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 300);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   // Every FM write taken from the block is matched against the oldest write owed.
   always @(posedge clock) begin : check_fm_writes
      fm_write_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fm_writes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected FM write: address %h data %h last %b",
                        rsp_fm_address, rsp_fm_data, rsp_last_write);
            end
         end else begin
            due = fm_writes_due.pop_front();
            if (rsp_fm_address !== due.address || rsp_fm_data !== due.data ||
                rsp_last_write !== due.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("FM write mismatch: expected %h/%h/%b, got %h/%h/%b",
                           due.address, due.data, due.last,
                           rsp_fm_address, rsp_fm_data, rsp_last_write);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      foreach (shadow_file[i]) shadow_file[i] = 8'h00;
      noise_volume_on = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The register comes out of reset set; write it set again while idle.
      write_noise_volume(1'b1);
      test_tone_periods();
      test_levels_and_mixer();
      test_ignored_registers();
      drain_block();
      test_noise_volume_off();
      drain_block();

      // Random phases, each under its own setting of the noise volume switch.
      write_noise_volume(1'b1);
      test_random_traffic(100);
      drain_block();
      write_noise_volume(1'b0);
      test_random_traffic(100);
      drain_block();
      write_noise_volume(1'($urandom_range(0, 1)));
      test_random_traffic(100);
      drain_block();
      write_noise_volume(1'b1);
      test_random_traffic(100);
      drain_block();
      write_noise_volume(1'b0);
      test_random_traffic(100);

      // Final drain: all owed writes seen, then a quiet spell for stray extra writes.
      drain_block();
      if (mismatch_count == 0 && fm_writes_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/ptfm_pkg.sv
rtl/ptfm_div.sv
rtl/ptfm_dp.sv
rtl/ptfm_ctrl.sv
rtl/psg_to_fm_register_translator.sv
dv/tb_top.sv
